// ===== design/stq_pkg.sv =====
// Shared types, codes and helpers for the sorted timer queue.
`default_nettype none

package stq_pkg;

  localparam int ID_W        = 4;
  localparam int TIME_W      = 32;
  localparam int NUM_IDS     = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [1:0]        cmd_t;
  typedef logic [1:0]        status_t;
  typedef logic [ID_W-1:0]   tid_t;
  typedef logic [TIME_W-1:0] tms_t;

  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_EXPIRE = 2'd2;
  localparam cmd_t CMD_QUERY  = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_DUP      = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  typedef struct packed {
    tid_t id;
    tms_t deadline;
  } stq_entry_t;

  // true when the wrapping difference a - b is negative
  function automatic logic diff_neg(input tms_t a, input tms_t b);
    tms_t d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

// ===== design/stq_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none

interface stq_in_if;
  import stq_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  command;
  tid_t  timer_id;
  tms_t  deadline;
  tms_t  now_ms;

  modport source (output valid, command, timer_id, deadline, now_ms, input ready);
  modport sink   (input valid, command, timer_id, deadline, now_ms, output ready);
endinterface

interface stq_out_if;
  import stq_pkg::*;
  logic               valid;
  logic               ready;
  logic               expired_valid;
  tid_t               expired_id;
  status_t            status;
  logic signed [31:0] time_until;
  logic               last;

  modport source (output valid, expired_valid, expired_id, status, time_until, last,
                  input ready);
  modport sink   (input valid, expired_valid, expired_id, status, time_until, last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/stq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sorted_timer_queue.sv =====
// Top level: deadline-ordered timer queue kept in a circular RAM.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------------
//  in_ch   | in  | valid / ready | command, timer_id, deadline, now_ms
//  out_ch  | out | valid / ready | expired_valid, expired_id, status, time_until, last
//
// One command at a time; in_ch.ready is high only when idle. Add: a read pass over the
// entries through the registered RAM read, then the tail write, then the response; an empty
// queue skips the read pass. Remove: a read pass, then the response. Rejected add or remove:
// the response alone. Expire: pops due timers from the head, up to MAX_RESULTS, then a final
// beat. Query: reads the head, then responds, or responds at once when empty. Reset (sync,
// rst_n low) empties the queue; RAM contents need no clearing. A full output register
// stalls the sequencer.
`default_nettype none

module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stq_in_if.sink     in_ch,
  stq_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);      // physical RAM address
  localparam int IW = $clog2(DEPTH + 1);  // logical index / occupancy

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;   // add/remove pass over entries
  localparam logic [3:0] S_FIN  = 4'd2;   // add: write tail entry
  localparam logic [3:0] S_XRD  = 4'd3;   // expire: read head
  localparam logic [3:0] S_XEV  = 4'd4;   // expire: compare head with now
  localparam logic [3:0] S_XEND = 4'd5;   // expire: final beat
  localparam logic [3:0] S_QRD  = 4'd6;
  localparam logic [3:0] S_QEV  = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;   // single-beat response

  // physical slot of a logical position, queue starts at head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, l};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // control state
  logic [3:0]         state_r, state_nxt;
  logic [IW-1:0]      occ_r, occ_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [NUM_IDS-1:0] present_r, present_nxt;   // ids currently queued
  logic               out_vld_r, out_vld_nxt;

  // working registers of the current command
  cmd_t       cmd_r, cmd_nxt;
  tid_t       id_r, id_nxt;
  tms_t       dl_r, dl_nxt;
  tms_t       now_r, now_nxt;
  status_t    res_st_r, res_st_nxt;
  tms_t       res_tu_r, res_tu_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rsp_vld_r, rsp_vld_nxt;
  logic [IW-1:0] rsp_idx_r, rsp_idx_nxt;
  logic          ins_r, ins_nxt;        // add: new entry already placed
  logic          found_r, found_nxt;    // remove: victim passed, shift down
  stq_entry_t    carry_r, carry_nxt;    // add: entry displaced by one slot
  logic          pend_vld_r, pend_vld_nxt;  // expire: popped, not yet sent
  tid_t          pend_id_r, pend_id_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // output payload registers
  logic    out_xv_r;
  tid_t    out_id_r;
  status_t out_st_r;
  tms_t    out_tu_r;
  logic    out_last_r;

  // RAM port
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_l, wr_l;
  stq_entry_t    wr_data, rd_data;
  logic [AW-1:0] rd_addr, wr_addr;

  // output register load
  logic    ld, ld_xv, ld_last;
  tid_t    ld_id;
  status_t ld_st;
  tms_t    ld_tu;
  logic    out_free;
  logic    due;

  assign out_free = !out_vld_r || out_ch.ready;
  assign rd_addr  = phys(head_r, rd_l[AW-1:0]);
  assign wr_addr  = phys(head_r, wr_l[AW-1:0]);
  assign due      = (rd_data.deadline == now_r) || diff_neg(rd_data.deadline, now_r);

  stq_ram #(
    .WIDTH ($bits(stq_entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    head_nxt     = head_r;
    present_nxt  = present_r;
    cmd_nxt      = cmd_r;
    id_nxt       = id_r;
    dl_nxt       = dl_r;
    now_nxt      = now_r;
    res_st_nxt   = res_st_r;
    res_tu_nxt   = res_tu_r;
    rd_idx_nxt   = rd_idx_r;
    rsp_vld_nxt  = rsp_vld_r;
    rsp_idx_nxt  = rsp_idx_r;
    ins_nxt      = ins_r;
    found_nxt    = found_r;
    carry_nxt    = carry_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    cnt_nxt      = cnt_r;
    rd_en   = 1'b0;
    rd_l    = '0;
    wr_en   = 1'b0;
    wr_l    = '0;
    wr_data = '0;
    ld      = 1'b0;
    ld_xv   = 1'b0;
    ld_id   = '0;
    ld_st   = ST_OK;
    ld_tu   = '0;
    ld_last = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt      = in_ch.command;
          id_nxt       = in_ch.timer_id;
          dl_nxt       = in_ch.deadline;
          now_nxt      = in_ch.now_ms;
          res_st_nxt   = ST_OK;
          res_tu_nxt   = '0;
          rd_idx_nxt   = '0;
          rsp_vld_nxt  = 1'b0;
          ins_nxt      = 1'b0;
          found_nxt    = 1'b0;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          case (in_ch.command)
            CMD_ADD: begin
              // duplicate check ranks ahead of full check
              if (present_r[in_ch.timer_id]) begin
                res_st_nxt = ST_DUP;
                state_nxt  = S_RESP;
              end else if (occ_r == IW'(DEPTH)) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else if (occ_r == '0) begin
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (!present_r[in_ch.timer_id]) begin
                res_st_nxt = ST_NOTFOUND;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_EXPIRE: state_nxt = S_XRD;
            default:    state_nxt = S_QRD;
          endcase
        end
      end

      S_SCAN: begin
        // read stage: one logical entry per cycle
        if (rd_idx_r < occ_r) begin
          rd_en       = 1'b1;
          rd_l        = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + IW'(1);
          rsp_vld_nxt = 1'b1;
          rsp_idx_nxt = rd_idx_r;
        end else begin
          rsp_vld_nxt = 1'b0;
        end
        // write stage: data of rsp_idx arrived from the RAM
        if (rsp_vld_r) begin
          if (cmd_r == CMD_ADD) begin
            if (ins_r) begin
              wr_en     = 1'b1;
              wr_l      = rsp_idx_r;
              wr_data   = carry_r;
              carry_nxt = rd_data;
            end else if (diff_neg(dl_r, rd_data.deadline)) begin
              wr_en     = 1'b1;
              wr_l      = rsp_idx_r;
              wr_data   = stq_entry_t'{id: id_r, deadline: dl_r};
              carry_nxt = rd_data;
              ins_nxt   = 1'b1;
            end
          end else begin
            if (found_r) begin
              wr_en   = 1'b1;
              wr_l    = rsp_idx_r - IW'(1);
              wr_data = rd_data;
            end else if (rd_data.id == id_r) begin
              found_nxt = 1'b1;
            end
          end
          if (rsp_idx_r == occ_r - IW'(1)) begin
            if (cmd_r == CMD_ADD) begin
              state_nxt = S_FIN;
            end else begin
              occ_nxt           = occ_r - IW'(1);
              present_nxt[id_r] = 1'b0;
              state_nxt         = S_RESP;
            end
          end
        end
      end

      S_FIN: begin
        wr_en             = 1'b1;
        wr_l              = occ_r;
        wr_data           = ins_r ? carry_r : stq_entry_t'{id: id_r, deadline: dl_r};
        occ_nxt           = occ_r + IW'(1);
        present_nxt[id_r] = 1'b1;
        state_nxt         = S_RESP;
      end

      S_XRD: begin
        if (occ_r == '0 || cnt_r == CNT_W'(MAX_RESULTS)) begin
          state_nxt = S_XEND;
        end else begin
          rd_en     = 1'b1;
          rd_l      = '0;
          state_nxt = S_XEV;
        end
      end

      S_XEV: begin
        // a popped timer is held back until the next pop or the final beat, so the final one carries last
        if (due) begin
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              ld    = 1'b1;
              ld_xv = 1'b1;
              ld_id = pend_id_r;
            end
            pend_vld_nxt             = 1'b1;
            pend_id_nxt              = rd_data.id;
            present_nxt[rd_data.id]  = 1'b0;
            head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
            occ_nxt   = occ_r - IW'(1);
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = S_XRD;
          end
        end else begin
          state_nxt = S_XEND;
        end
      end

      S_XEND: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_xv     = pend_vld_r;
          ld_id     = pend_vld_r ? pend_id_r : '0;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_QRD: begin
        if (occ_r == '0) begin
          res_tu_nxt = '1;
          state_nxt  = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_l      = '0;
          state_nxt = S_QEV;
        end
      end

      S_QEV: begin
        res_tu_nxt = diff_neg(rd_data.deadline, now_r) ? '0 : rd_data.deadline - now_r;
        state_nxt  = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_st     = res_st_r;
          ld_tu     = res_tu_r;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_vld_nxt = ld ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      head_r    <= '0;
      present_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      head_r    <= head_nxt;
      present_r <= present_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    dl_r       <= dl_nxt;
    now_r      <= now_nxt;
    res_st_r   <= res_st_nxt;
    res_tu_r   <= res_tu_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rsp_vld_r  <= rsp_vld_nxt;
    rsp_idx_r  <= rsp_idx_nxt;
    ins_r      <= ins_nxt;
    found_r    <= found_nxt;
    carry_r    <= carry_nxt;
    pend_vld_r <= pend_vld_nxt;
    pend_id_r  <= pend_id_nxt;
    cnt_r      <= cnt_nxt;
    if (ld) begin
      out_xv_r   <= ld_xv;
      out_id_r   <= ld_id;
      out_st_r   <= ld_st;
      out_tu_r   <= ld_tu;
      out_last_r <= ld_last;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.expired_valid = out_xv_r;
  assign out_ch.expired_id    = out_id_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.time_until    = $signed(out_tu_r);
  assign out_ch.last          = out_last_r;

  // occupancy never exceeds the RAM
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= IW'(DEPTH))
    else $error("occupancy above depth");

  // id set and occupancy move together
  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(occ_r))
    else $error("id presence out of step with occupancy");

  // shifting never reads the slot being written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("RAM read and write hit the same slot");

  // a beat reporting a popped timer carries no status or time
  a_pop_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_xv_r) |-> (out_st_r == ST_OK && out_tu_r == '0))
    else $error("popped timer beat with status or time set");

endmodule

`default_nettype wire
